// ===== sv/cmdtok_pkg.sv =====
// Shared types, constants and helper functions for the command line tokenizer.
// Holds the keyword table, character codes and the item and result structures.
// Used by every module of the block; depends on nothing else.
package cmdtok_pkg;

    // Keyword table geometry and fixed field widths.
    localparam int KW_ROWS    = 10;
    localparam int KW_CHARS   = 10;
    localparam int CAND_W     = 10;
    localparam int TOKEN_W    = 32;
    localparam int OUT_TOKENS = 4;

    localparam logic [3:0] CHAR_INDEX_MAX = 4'd15;

    // Keyword text, right-justified: the first character sits in the highest used byte.
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_ROWS] = '{
        "break", "card", "reset", "initialize", "blocks",
        "record", "list", "log", "replay", "test"
    };
    localparam logic [3:0] KW_LEN [KW_ROWS] = '{
        4'd5, 4'd4, 4'd5, 4'd10, 4'd6, 4'd6, 4'd4, 4'd3, 4'd6, 4'd4
    };

    // Identifier event codes.
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_UNKNOWN   = 2'd1;
    localparam logic [1:0] EV_AMBIGUOUS = 2'd2;

    // Statement completion codes.
    localparam logic [1:0] DONE_NONE    = 2'd0;
    localparam logic [1:0] DONE_READY   = 2'd1;
    localparam logic [1:0] DONE_DISCARD = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // One input word.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       starts_packet;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [1:0]                           ident_event;
        logic [CAND_W-1:0]                    candidates;
        logic                                 bad_char;
        logic [1:0]                           stmt_done;
        logic [2:0]                           token_count;
        logic [OUT_TOKENS-1:0][TOKEN_W-1:0]   tokens;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Character at position pos of a keyword of length len.
    function automatic logic [7:0] kw_byte(input logic [KW_CHARS*8-1:0] text,
                                           input logic [3:0] len,
                                           input logic [3:0] pos);
        logic [7:0] b;
        logic [3:0] slot;
        b    = '0;
        slot = len - 4'd1 - pos;
        for (int j = 0; j < KW_CHARS; j++) begin
            if (slot == 4'(j)) begin
                b = text[j*8 +: 8];
            end
        end
        return b;
    endfunction

endpackage

// ===== sv/command_line_tokenizer.sv =====
// Top level of the command line tokenizer: input and output word registers
// around the lexer. Depends on cmdtok_pkg and cmdtok_lexer.
//
// The tokenizer takes one console word per clock cycle unless the result side
// stalls. When a word ends a statement, reports an identifier problem or hits a
// bad character, the block offers one result word once the word has passed the
// input register, the lexer step and the result register, or later while the
// result register is still held. The rate rests on the lexer step, which updates
// all state (keyword mismatch mask, decimal accumulator, token store) between the
// input register and the result register. The input register takes a new word
// when it is empty or when its word moves on, and a word moves on only when the
// result register is free or being read. So while a result waits at the output
// one more word can be taken, and then the input stalls until the result is read.
// Words that produce no result simply advance the state and leave nothing behind.
module command_line_tokenizer #(
    parameter int MAX_TOKENS   = 4,
    parameter int NUM_KEYWORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_starts_packet,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_ident_event,
    output logic [9:0]  o_candidates,
    output logic        o_bad_char,
    output logic [1:0]  o_stmt_done,
    output logic [2:0]  o_token_count,
    output logic [31:0] o_token_first,
    output logic [31:0] o_token_second,
    output logic [31:0] o_token_third,
    output logic [31:0] o_token_fourth
);

    logic                 r_in_valid;
    cmdtok_pkg::t_item    r_in_item;
    logic                 r_out_valid;
    cmdtok_pkg::t_result  r_out;
    logic                 step;
    logic                 has_result;
    cmdtok_pkg::t_result  result;

    // A held word is processed once the result register can take its result.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item.cmd           <= i_cmd;
            r_in_item.data_byte     <= i_data_byte;
            r_in_item.starts_packet <= i_starts_packet;
        end
    end

    cmdtok_lexer #(
        .MAX_TOKENS   (MAX_TOKENS),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_in_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ident_event  = r_out.ident_event;
    assign o_candidates   = r_out.candidates;
    assign o_bad_char     = r_out.bad_char;
    assign o_stmt_done    = r_out.stmt_done;
    assign o_token_count  = r_out.token_count;
    assign o_token_first  = r_out.tokens[0];
    assign o_token_second = r_out.tokens[1];
    assign o_token_third  = r_out.tokens[2];
    assign o_token_fourth = r_out.tokens[3];

endmodule

// ===== sv/cmdtok_kw_match.sv =====
// Keyword matcher: compares one character against all keywords in parallel and
// resolves a finished identifier into a keyword index or an error event.
// Depends on cmdtok_pkg for the keyword table and event codes.
module cmdtok_kw_match #(
    parameter int NUM_KEYWORDS = 10
) (
    input  logic [NUM_KEYWORDS-1:0]        i_mask_in,
    input  logic [3:0]                     i_char_index,
    input  logic [7:0]                     i_char,
    output logic [NUM_KEYWORDS-1:0]        o_mask_next,
    input  logic [NUM_KEYWORDS-1:0]        i_mask,
    output logic [1:0]                     o_ident_event,
    output logic [cmdtok_pkg::CAND_W-1:0]  o_candidates,
    output logic [cmdtok_pkg::TOKEN_W-1:0] o_kw_index
);

    localparam int IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    logic [NUM_KEYWORDS-1:0]       hit;
    logic [NUM_KEYWORDS-1:0]       live;
    logic [cmdtok_pkg::CAND_W-1:0] cand_all;
    logic [IDX_W-1:0]              idx;

    // A keyword survives a character only if it is long enough and the character agrees.
    for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
        if (k < cmdtok_pkg::KW_ROWS) begin : g_row
            assign hit[k] = (i_char_index < cmdtok_pkg::KW_LEN[k]) &&
                            (i_char == cmdtok_pkg::kw_byte(cmdtok_pkg::KW_TEXT[k],
                                                           cmdtok_pkg::KW_LEN[k],
                                                           i_char_index));
        end else begin : g_none
            assign hit[k] = 1'b0;
        end
    end

    assign o_mask_next = i_mask_in | ~hit;

    // Keywords still in the running when the identifier ends.
    assign live = ~i_mask;

    for (genvar b = 0; b < cmdtok_pkg::CAND_W; b++) begin : g_cand
        if (b < NUM_KEYWORDS) begin : g_live
            assign cand_all[b] = live[b];
        end else begin : g_zero
            assign cand_all[b] = 1'b0;
        end
    end

    // Encode the single surviving keyword; only meaningful when exactly one bit is set.
    always_comb begin
        idx = '0;
        for (int b = 0; b < NUM_KEYWORDS; b++) begin
            if (live[b]) begin
                idx = idx | IDX_W'(b);
            end
        end
    end

    always_comb begin
        o_ident_event = cmdtok_pkg::EV_NONE;
        o_candidates  = '0;
        if (live == '0) begin
            o_ident_event = cmdtok_pkg::EV_UNKNOWN;
        end else if ((live & (live - 1'b1)) != '0) begin
            o_ident_event = cmdtok_pkg::EV_AMBIGUOUS;
            o_candidates  = cand_all;
        end
    end

    assign o_kw_index = cmdtok_pkg::TOKEN_W'(idx);

endmodule

// ===== sv/cmdtok_lexer.sv =====
// Lexer state and single-step update: takes one word, updates the tokenizer
// state and forms the result word that the step causes, if any.
// Depends on cmdtok_pkg and cmdtok_kw_match.
module cmdtok_lexer #(
    parameter int MAX_TOKENS   = 4,
    parameter int NUM_KEYWORDS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  cmdtok_pkg::t_item     i_item,
    output logic                  o_has_result,
    output cmdtok_pkg::t_result   o_result
);

    localparam int TALLY_W = $clog2(MAX_TOKENS + 1);
    localparam int TIDX_W  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int TW      = cmdtok_pkg::TOKEN_W;

    // Lexer modes.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_INT   = 2'd2;

    // Console phases.
    localparam logic [1:0] PH_PRIMING = 2'd0;
    localparam logic [1:0] PH_PRIMED  = 2'd1;
    localparam logic [1:0] PH_FIRED   = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    logic [1:0]              r_mode,  n_mode;
    logic [1:0]              r_phase, n_phase;
    logic [NUM_KEYWORDS-1:0] r_mask,  n_mask;
    logic [TW-1:0]           r_acc,   n_acc;
    logic [3:0]              r_ci,    n_ci;
    logic [TW-1:0]           r_tokens [MAX_TOKENS];
    logic [TW-1:0]           n_tokens [MAX_TOKENS];
    logic [TALLY_W-1:0]      r_tally, n_tally;
    logic                    r_skip,  n_skip;

    logic [NUM_KEYWORDS-1:0]       mask_in;
    logic [NUM_KEYWORDS-1:0]       mask_next;
    logic [3:0]                    ci_in;
    logic [3:0]                    ci_next;
    logic [1:0]                    kw_event;
    logic [cmdtok_pkg::CAND_W-1:0] kw_cand;
    logic [TW-1:0]                 kw_index;

    logic [7:0]                    c;
    logic                          between;
    logic                          push_en;
    logic [TW-1:0]                 push_val;
    logic [1:0]                    ev;
    logic [cmdtok_pkg::CAND_W-1:0] cand;
    logic                          bad;
    logic [1:0]                    done;

    assign c = i_item.data_byte;

    // The matcher continues an identifier or starts a fresh one from an empty mask.
    assign mask_in = (r_mode == MODE_IDENT) ? r_mask : '0;
    assign ci_in   = (r_mode == MODE_IDENT) ? r_ci : 4'd0;
    assign ci_next = (ci_in < cmdtok_pkg::CHAR_INDEX_MAX) ? ci_in + 4'd1 : ci_in;

    cmdtok_kw_match #(
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_kw_match (
        .i_mask_in     (mask_in),
        .i_char_index  (ci_in),
        .i_char        (c),
        .o_mask_next   (mask_next),
        .i_mask        (r_mask),
        .o_ident_event (kw_event),
        .o_candidates  (kw_cand),
        .o_kw_index    (kw_index)
    );

    // Next state for one accepted word.
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_mask   = r_mask;
        n_acc    = r_acc;
        n_ci     = r_ci;
        n_tokens = r_tokens;
        n_tally  = r_tally;
        n_skip   = r_skip;
        between  = 1'b0;
        push_en  = 1'b0;
        push_val = '0;
        ev       = cmdtok_pkg::EV_NONE;
        cand     = '0;
        bad      = 1'b0;
        done     = cmdtok_pkg::DONE_NONE;

        if (i_step) begin
            if (i_item.cmd) begin
                // The waiting statement has been executed.
                if (r_phase == PH_PRIMED) begin
                    n_phase = PH_FIRED;
                end
            end else begin
                // A new packet is ignored while primed, releases an executed statement, and is otherwise lexed.
                if (i_item.starts_packet) begin
                    n_skip = 1'b0;
                    if (r_phase == PH_PRIMED) begin
                        n_skip = 1'b1;
                    end else if (r_phase == PH_FIRED) begin
                        for (int t = 0; t < MAX_TOKENS; t++) begin
                            n_tokens[t] = '0;
                        end
                        n_tally = '0;
                        n_phase = PH_PRIMING;
                    end
                end

                if (!n_skip) begin
                    between = 1'b1;
                    case (r_mode)
                        MODE_IDENT: begin
                            if (cmdtok_pkg::is_letter(c) || cmdtok_pkg::is_digit(c) ||
                                c == cmdtok_pkg::CH_UNDERSCORE) begin
                                n_mask  = mask_next;
                                n_ci    = ci_next;
                                between = 1'b0;
                            end else begin
                                ev      = kw_event;
                                cand    = kw_cand;
                                push_en = 1'b1;
                                if (kw_event == cmdtok_pkg::EV_NONE) begin
                                    push_val = kw_index;
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                                n_mode = MODE_NONE;
                                n_mask = '0;
                                n_ci   = 4'd0;
                            end
                        end
                        MODE_INT: begin
                            if (cmdtok_pkg::is_digit(c)) begin
                                // acc * 10 + digit, wrapping at 32 bits.
                                n_acc   = {r_acc[TW-4:0], 3'b000} + {r_acc[TW-2:0], 1'b0} +
                                          TW'(c[3:0]);
                                between = 1'b0;
                            end else begin
                                push_en  = 1'b1;
                                push_val = r_acc;
                                n_acc    = '0;
                                n_mode   = MODE_NONE;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // The byte as seen between tokens, also the byte that ended a token.
                    if (between) begin
                        if (c == cmdtok_pkg::CH_SPACE || c == cmdtok_pkg::CH_TAB) begin
                            n_mode = n_mode;
                        end else if (cmdtok_pkg::is_letter(c) ||
                                     c == cmdtok_pkg::CH_UNDERSCORE) begin
                            n_mode = MODE_IDENT;
                            n_mask = mask_next;
                            n_ci   = ci_next;
                        end else if (cmdtok_pkg::is_digit(c)) begin
                            n_mode = MODE_INT;
                            n_acc  = TW'(c[3:0]);
                        end else if (c == cmdtok_pkg::CH_CR || c == cmdtok_pkg::CH_LF ||
                                     c == cmdtok_pkg::CH_COMMA) begin
                            if (n_phase == PH_ERROR) begin
                                n_phase = PH_FIRED;
                                done    = cmdtok_pkg::DONE_DISCARD;
                            end else begin
                                n_phase = PH_PRIMED;
                                done    = cmdtok_pkg::DONE_READY;
                            end
                        end else begin
                            bad    = 1'b1;
                            n_skip = 1'b1;
                        end
                    end

                    // Store the finished token while there is room; later ones are dropped.
                    if (push_en && (32'(n_tally) < 32'(MAX_TOKENS))) begin
                        n_tokens[n_tally[TIDX_W-1:0]] = push_val;
                        n_tally = n_tally + 1'b1;
                    end
                end
            end
        end
    end

    // Result word for this step.
    always_comb begin
        o_has_result = (ev != cmdtok_pkg::EV_NONE) || bad || (done != cmdtok_pkg::DONE_NONE);
        o_result.ident_event = ev;
        o_result.candidates  = cand;
        o_result.bad_char    = bad;
        o_result.stmt_done   = done;
        o_result.token_count = (32'(n_tally) > 32'd7) ? 3'd7 : 3'(n_tally);
        for (int i = 0; i < cmdtok_pkg::OUT_TOKENS; i++) begin
            o_result.tokens[i] = '0;
            if (i < MAX_TOKENS && 32'(i) < 32'(n_tally)) begin
                o_result.tokens[i] = n_tokens[i];
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NONE;
            r_phase <= PH_PRIMING;
            r_mask  <= '0;
            r_acc   <= '0;
            r_ci    <= 4'd0;
            r_tally <= '0;
            r_skip  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_acc   <= n_acc;
            r_ci    <= n_ci;
            r_tally <= n_tally;
            r_skip  <= n_skip;
        end
    end

    // Token store; entries above the tally are never shown.
    always_ff @(posedge i_clk) begin
        r_tokens <= n_tokens;
    end

endmodule

// ===== sv/cmdtok_checker.sv =====
// Port-level checks for the command line tokenizer, bound to the top level.
// Depends on cmdtok_pkg for the event and completion codes.
module cmdtok_checker #(
    parameter int MAX_TOKENS = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_ident_event,
    input logic [9:0]  o_candidates,
    input logic        o_bad_char,
    input logic [1:0]  o_stmt_done,
    input logic [2:0]  o_token_count,
    input logic [31:0] o_token_first,
    input logic [31:0] o_token_second,
    input logic [31:0] o_token_third,
    input logic [31:0] o_token_fourth
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_ident_event) && $stable(o_candidates) && $stable(o_bad_char) &&
            $stable(o_stmt_done) && $stable(o_token_count) && $stable(o_token_first) &&
            $stable(o_token_second) && $stable(o_token_third) && $stable(o_token_fourth))
        else $error("result word changed while stalled");

    // Every result word reports something.
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ident_event != cmdtok_pkg::EV_NONE) || o_bad_char ||
                        (o_stmt_done != cmdtok_pkg::DONE_NONE))
        else $error("empty result word delivered");

    // Candidates are shown only for an ambiguous identifier, and then at least two.
    a_candidates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ident_event == cmdtok_pkg::EV_AMBIGUOUS) ?
                        ($countones(o_candidates) >= 2) : (o_candidates == '0))
        else $error("candidate mask inconsistent with identifier event");

    // The token count never exceeds the store size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_token_count) <= 32'(MAX_TOKENS))
        else $error("token count beyond store size");

endmodule

bind command_line_tokenizer cmdtok_checker #(.MAX_TOKENS(MAX_TOKENS)) u_checker (.*);

// ===== tb/tb_command_line_tokenizer.sv =====
// Self-checking testbench for command_line_tokenizer: drives console words and
// executed commands, predicts every result word and checks it field by field.
// Depends on cmdtok_pkg and the command_line_tokenizer RTL.
`timescale 1ns / 1ps

module tb_command_line_tokenizer;

    localparam int MAX_TOKENS   = 4;
    localparam int NUM_KEYWORDS = 10;
    localparam logic [NUM_KEYWORDS-1:0] ALL_KEYWORDS = '1;

    localparam int ITEM_TARGET  = 1100;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {LEX_NONE, LEX_IDENT, LEX_INT} t_lex_mode;
    typedef enum logic [1:0] {
        PHASE_PRIMING, PHASE_PRIMED, PHASE_FIRED, PHASE_ERROR
    } t_phase;

    // Tokenizer predictor and queue of the result words it still expects.
    class t_tokenizer_scoreboard;
        string                   keyword_text [NUM_KEYWORDS];
        t_lex_mode               lex;
        t_phase                  phase;
        logic [NUM_KEYWORDS-1:0] miss;
        logic [31:0]             acc;
        logic [3:0]              pos;
        logic [31:0]             held_tokens [MAX_TOKENS];
        logic [2:0]              held_count;
        logic                    dropping;
        cmdtok_pkg::t_result     expected_q [$];
        int                      errors;
        int                      worked;

        function new();
            keyword_text = '{"break", "card", "reset", "initialize", "blocks",
                             "record", "list", "log", "replay", "test"};
            lex        = LEX_NONE;
            phase      = PHASE_PRIMING;
            miss       = '0;
            acc        = '0;
            pos        = '0;
            held_count = '0;
            dropping   = 1'b0;
            errors     = 0;
            worked     = 0;
            foreach (held_tokens[i]) held_tokens[i] = '0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= cmdtok_pkg::CH_LOWER_A && c <= cmdtok_pkg::CH_LOWER_Z) ||
                   (c >= cmdtok_pkg::CH_UPPER_A && c <= cmdtok_pkg::CH_UPPER_Z);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= cmdtok_pkg::CH_ZERO && c <= cmdtok_pkg::CH_NINE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_token(logic [31:0] v);
            if (held_count < MAX_TOKENS) begin
                held_tokens[held_count] = v;
                held_count++;
            end
        endfunction

        // Strike every keyword that disagrees with this letter at this position.
        function void advance_match(logic [7:0] c);
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                if (!miss[k]) begin
                    if (int'(pos) >= keyword_text[k].len() ||
                        c != keyword_text[k][int'(pos)]) begin
                        miss[k] = 1'b1;
                    end
                end
            end
            if (pos != cmdtok_pkg::CHAR_INDEX_MAX) begin
                pos++;
            end
        endfunction

        // Advance the predicted state by one accepted word.
        function void note_word(logic cmd, logic [7:0] c, logic sp);
            cmdtok_pkg::t_result exp;
            logic [NUM_KEYWORDS-1:0] live;
            int idx;
            exp = '0;
            worked++;
            if (cmd) begin
                if (phase == PHASE_PRIMED) begin
                    phase = PHASE_FIRED;
                end
                return;
            end
            if (sp) begin
                dropping = 1'b0;
                if (phase == PHASE_PRIMED) begin
                    dropping = 1'b1;
                end else if (phase == PHASE_FIRED) begin
                    foreach (held_tokens[i]) held_tokens[i] = '0;
                    held_count = '0;
                    phase = PHASE_PRIMING;
                end
            end
            if (dropping) return;

            // A pending identifier or integer either grows or is closed here.
            if (lex == LEX_IDENT) begin
                if (is_letter(c) || is_digit(c) || c == cmdtok_pkg::CH_UNDERSCORE) begin
                    advance_match(c);
                    return;
                end
                live = ~miss & ALL_KEYWORDS;
                if (live == '0) begin
                    exp.ident_event = cmdtok_pkg::EV_UNKNOWN;
                    push_token('0);
                    phase = PHASE_ERROR;
                end else if ((live & (live - 1'b1)) != '0) begin
                    exp.ident_event = cmdtok_pkg::EV_AMBIGUOUS;
                    exp.candidates  = live;
                    push_token('0);
                    phase = PHASE_ERROR;
                end else begin
                    idx = 0;
                    for (int k = 0; k < NUM_KEYWORDS; k++) begin
                        if (live[k]) idx = k;
                    end
                    push_token(32'(idx));
                end
                lex  = LEX_NONE;
                miss = '0;
                pos  = '0;
            end else if (lex == LEX_INT) begin
                if (is_digit(c)) begin
                    acc = acc * 32'd10 + 32'(c - cmdtok_pkg::CH_ZERO);
                    return;
                end
                push_token(acc);
                acc = '0;
                lex = LEX_NONE;
            end

            // The byte seen as one between tokens.
            if (c == cmdtok_pkg::CH_SPACE || c == cmdtok_pkg::CH_TAB) begin
                // Blanks are skipped.
            end else if (is_letter(c) || c == cmdtok_pkg::CH_UNDERSCORE) begin
                lex  = LEX_IDENT;
                miss = '0;
                pos  = '0;
                advance_match(c);
            end else if (is_digit(c)) begin
                lex = LEX_INT;
                acc = 32'(c - cmdtok_pkg::CH_ZERO);
            end else if (c == cmdtok_pkg::CH_CR || c == cmdtok_pkg::CH_LF ||
                         c == cmdtok_pkg::CH_COMMA) begin
                if (phase == PHASE_ERROR) begin
                    phase = PHASE_FIRED;
                    exp.stmt_done = cmdtok_pkg::DONE_DISCARD;
                end else begin
                    phase = PHASE_PRIMED;
                    exp.stmt_done = cmdtok_pkg::DONE_READY;
                end
            end else begin
                exp.bad_char = 1'b1;
                dropping = 1'b1;
            end

            if (exp.ident_event == cmdtok_pkg::EV_NONE && !exp.bad_char &&
                exp.stmt_done == cmdtok_pkg::DONE_NONE) return;
            exp.token_count = held_count;
            for (int i = 0; i < cmdtok_pkg::OUT_TOKENS; i++) begin
                exp.tokens[i] = (i < held_count) ? held_tokens[i] : '0;
            end
            expected_q.push_back(exp);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            end
        endfunction

        // Compare one delivered result word with the oldest expectation.
        function void check_result(cmdtok_pkg::t_result got);
            cmdtok_pkg::t_result exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            exp = expected_q.pop_front();
            compare_field("ident_event", 32'(exp.ident_event), 32'(got.ident_event));
            compare_field("candidates", 32'(exp.candidates), 32'(got.candidates));
            compare_field("bad_char", 32'(exp.bad_char), 32'(got.bad_char));
            compare_field("stmt_done", 32'(exp.stmt_done), 32'(got.stmt_done));
            compare_field("token_count", 32'(exp.token_count), 32'(got.token_count));
            compare_field("token_first", exp.tokens[0], got.tokens[0]);
            compare_field("token_second", exp.tokens[1], got.tokens[1]);
            compare_field("token_third", exp.tokens[2], got.tokens[2]);
            compare_field("token_fourth", exp.tokens[3], got.tokens[3]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [7:0]  i_data_byte;
    logic        i_starts_packet;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_ident_event;
    logic [9:0]  o_candidates;
    logic        o_bad_char;
    logic [1:0]  o_stmt_done;
    logic [2:0]  o_token_count;
    logic [31:0] o_token_first;
    logic [31:0] o_token_second;
    logic [31:0] o_token_third;
    logic [31:0] o_token_fourth;

    t_tokenizer_scoreboard sb;
    logic [7:0] line_q [$];
    bit         tx_bursts = 1'b1;
    bit         rx_bursts = 1'b1;
    bit         hold_req  = 1'b0;
    int         cycle_count = 0;

    command_line_tokenizer #(
        .MAX_TOKENS  (MAX_TOKENS),
        .NUM_KEYWORDS(NUM_KEYWORDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_starts_packet(i_starts_packet),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ident_event  (o_ident_event),
        .o_candidates   (o_candidates),
        .o_bad_char     (o_bad_char),
        .o_stmt_done    (o_stmt_done),
        .o_token_count  (o_token_count),
        .o_token_first  (o_token_first),
        .o_token_second (o_token_second),
        .o_token_third  (o_token_third),
        .o_token_fourth (o_token_fourth)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Note accepted words first, then check the delivered result word.
    always @(posedge i_clk) begin
        cmdtok_pkg::t_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_word(i_cmd, i_data_byte, i_starts_packet);
            end
            if (o_out_valid && i_out_ready) begin
                got.ident_event = o_ident_event;
                got.candidates  = o_candidates;
                got.bad_char    = o_bad_char;
                got.stmt_done   = o_stmt_done;
                got.token_count = o_token_count;
                got.tokens[0]   = o_token_first;
                got.tokens[1]   = o_token_second;
                got.tokens[2]   = o_token_third;
                got.tokens[3]   = o_token_fourth;
                sb.check_result(got);
            end
        end
    end

    // Run time guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_ready = 1'b1;
            end else if (rx_bursts && $urandom_range(0, 9) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Offer one word and hold it until accepted; called at a falling edge.
    task automatic send_word(input logic cmd, input logic [7:0] b, input logic sp);
        if (tx_bursts && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_cmd           = cmd;
        i_data_byte     = b;
        i_starts_packet = sp;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_text(input string s, input bit new_packet);
        for (int i = 0; i < s.len(); i++) begin
            send_word(1'b0, s[i], new_packet && i == 0);
        end
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_word(1'b0, line_q[i], i == 0);
    endtask

    task automatic send_exec();
        send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Random bytes with random packet starts.
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_word(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] ident_char(bit leading);
        int r;
        r = leading ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26) return cmdtok_pkg::CH_LOWER_A + 8'(r);
        if (r < 52) return cmdtok_pkg::CH_UPPER_A + 8'(r - 26);
        if (leading || r == 62) return cmdtok_pkg::CH_UNDERSCORE;
        return cmdtok_pkg::CH_ZERO + 8'(r - 52);
    endfunction

    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (sb.is_letter(b) || sb.is_digit(b) || b == cmdtok_pkg::CH_UNDERSCORE ||
                   b == cmdtok_pkg::CH_SPACE || b == cmdtok_pkg::CH_TAB ||
                   b == cmdtok_pkg::CH_CR || b == cmdtok_pkg::CH_LF ||
                   b == cmdtok_pkg::CH_COMMA);
        return b;
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(1, 2)) begin
            line_q.push_back($urandom_range(0, 2) == 0 ? cmdtok_pkg::CH_TAB :
                                                        cmdtok_pkg::CH_SPACE);
        end
    endfunction

    // One identifier or integer: keyword, prefix, unknown word or number.
    function automatic void add_token();
        int kind;
        int k;
        int n;
        kind = $urandom_range(0, 9);
        k    = $urandom_range(0, NUM_KEYWORDS - 1);
        if (kind < 6) begin
            n = (kind < 4) ? sb.keyword_text[k].len() :
                             $urandom_range(1, sb.keyword_text[k].len());
            for (int i = 0; i < n; i++) line_q.push_back(sb.keyword_text[k][i]);
            if (kind < 4 && $urandom_range(0, 7) == 0) line_q.push_back(ident_char(1'b0));
        end else if (kind == 6) begin
            line_q.push_back(ident_char(1'b1));
            repeat ($urandom_range(0, 19)) line_q.push_back(ident_char(1'b0));
        end else begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (n) line_q.push_back(cmdtok_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // A statement with its terminator; a broken one carries a stray byte.
    function automatic void add_statement(bit broken);
        int first;
        int n;
        int term;
        first = line_q.size();
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) add_blanks();
        for (int t = 0; t < n; t++) begin
            if (t > 0) add_blanks();
            add_token();
        end
        if (broken) line_q.insert($urandom_range(first, line_q.size()), stray_byte());
        term = $urandom_range(0, 2);
        line_q.push_back(term == 0 ? cmdtok_pkg::CH_CR :
                         (term == 1 ? cmdtok_pkg::CH_LF : cmdtok_pkg::CH_COMMA));
    endfunction

    initial begin
        int  pick;
        int  next_drain;
        bit  hold_done;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = 1'b0;
        i_data_byte     = '0;
        i_starts_packet = 1'b0;
        next_drain      = 250;
        hold_done       = 1'b0;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: executed command while priming, ambiguous prefix closed by
        // a comma, token overflow, packet skipped while primed, bad high byte.
        send_word(1'b1, 8'hFF, 1'b1);
        send_text("re,", 1'b1);
        send_text("t 1 2 3 4,", 1'b1);
        send_text("x", 1'b1);
        send_exec();
        send_word(1'b0, 8'hFF, 1'b1);
        send_text("q,", 1'b0);
        wait_drained();

        // Random statements, mostly well formed, with noise and broken ones.
        while (sb.worked < ITEM_TARGET) begin
            if (sb.worked >= ITEM_TARGET - CALM_TAIL) begin
                tx_bursts = 1'b0;
                rx_bursts = 1'b0;
            end
            if (!hold_done && sb.worked >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (sb.worked >= next_drain) begin
                wait_drained();
                next_drain += 250;
            end
            pick = $urandom_range(0, 99);
            line_q.delete();
            if (pick < 72) begin
                add_statement(1'b0);
                if ($urandom_range(0, 9) == 0) add_statement(1'b0);
                send_line();
            end else if (pick < 82) begin
                add_statement(1'b1);
                send_line();
            end else if (pick < 92) begin
                send_noise();
            end
            if (pick >= 92 || (pick < 82 && $urandom_range(0, 6) != 0)) send_exec();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: result words outstanding, expected 0, actual %0d",
                     $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
